[rtl/core/pru_pkg.sv]
// Shared types, constants and decode helpers for the packed raw sample unpacker.
package pru_pkg;

    localparam int MAX_ROW_WIDTH = 16384;

    localparam int DEPTH_W  = 5;
    localparam int WIDTH_W  = 15;
    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;   // holds 0..MAX_RESULTS
    localparam int IDX_W       = 3;   // indexes 0..MAX_RESULTS-1

    // Entries in the queue between front and back end.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Bit masks for the 10-bit low-part byte and 12-bit nibble split.
    localparam logic [7:0] LOW_MASK_0 = 8'h03;
    localparam logic [7:0] LOW_MASK_1 = 8'h0C;
    localparam logic [7:0] LOW_MASK_2 = 8'h30;
    localparam logic [7:0] LOW_MASK_3 = 8'hC0;
    localparam logic [7:0] NIBBLE_MASK = 8'h0F;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH    = 2'd1;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 15'd16384;

    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_8,
        MODE_10,
        MODE_12,
        MODE_16,
        MODE_GEN
    } t_mode;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][SAMPLE_W-1:0] samples;
        logic [CNT_W-1:0]                     count;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Depths above 16 behave as 16.
    function automatic logic [DEPTH_W-1:0] clamp_depth(input logic [DEPTH_W-1:0] depth);
        return (depth > 5'd16) ? 5'd16 : depth;
    endfunction

    function automatic t_mode decode_mode(input logic [DEPTH_W-1:0] d);
        t_mode m;
        unique case (d)
            5'd0:    m = MODE_NONE;
            5'd8:    m = MODE_8;
            5'd10:   m = MODE_10;
            5'd12:   m = MODE_12;
            5'd16:   m = MODE_16;
            default: m = MODE_GEN;
        endcase
        return m;
    endfunction

endpackage

[rtl/core/packed_raw_sample_unpacker.sv]
// Top level of the packed raw sample unpacker: front end, entry queue, back end.
//
// Input channel: one packed row byte per transfer (i_valid / o_stall), with
// i_row_end on the last byte of the row. Output channel: one unsigned 16-bit
// sample per transfer (o_valid / i_stall); o_last marks the final sample a
// byte caused. Bytes that cause no sample produce no output transfer.
// Config: i_cfg_we with i_cfg_index 0 = sample_depth, 1 = row_width; write
// only while idle. A depth write drops any partial group or bit residue.
// A byte taken is unpacked combinationally into a queue entry; the entry is
// registered in the queue, and its first sample then in the output register.
// Throughput: one byte per cycle while the receiver does not stall and each
// byte yields at most one sample; a byte yielding more samples holds the
// output while they leave one at a time through the single-sample output
// register. The two-entry queue absorbs that; o_stall rises only when it is full.
// Receiver stall: the output register holds its sample, the queue fills and
// then the input stalls. Reset: depth 16, row width 16384, queue empty,
// all packing state and the pixel count cleared; no clearing pass.
module packed_raw_sample_unpacker
    import pru_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [BYTE_W-1:0]     i_byte_value,
    input  logic                  i_row_end,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SAMPLE_W-1:0]   o_sample,
    output logic                  o_last
);

    // front -> queue
    logic      push;
    t_entry    push_entry;
    // queue -> back
    t_entry    head;
    t_q_status q_status;
    logic      pop;

    // unpacking happens entirely here; state advances on each input transfer
    pru_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .i_byte_value (i_byte_value),
        .i_row_end    (i_row_end),
        .o_stall      (o_stall),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    // decouples byte intake from sample delivery
    pru_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // walks each entry into the output register one sample per cycle while i_stall is low
    pru_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_sample   (o_sample),
        .o_last     (o_last)
    );

endmodule

[rtl/core/pru_front.sv]
// Front end: takes bytes and config writes, unpacks each byte into a result entry.
module pru_front
    import pru_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  logic [BYTE_W-1:0]     i_byte_value,
    input  logic                  i_row_end,
    output logic                  o_stall,
    input  t_q_status             i_q_status,
    output logic                  o_push,
    output t_entry                o_entry
);

    logic [DEPTH_W-1:0] r_depth;
    logic [WIDTH_W-1:0] r_row_width;
    logic [23:0]        r_acc,       n_acc;
    logic [4:0]         r_bits_held, n_bits_held;
    logic [31:0]        r_group,     n_group;
    logic [2:0]         r_fill,      n_fill;
    logic [WIDTH_W-1:0] r_pixels,    n_pixels;
    logic               r_tail,      n_tail;

    logic                                 accept;
    logic [DEPTH_W-1:0]                   d;
    t_mode                                mode;
    logic [WIDTH_W-1:0]                   lim;
    logic [WIDTH_W-1:0]                   rem;
    logic [MAX_RESULTS-1:0][SAMPLE_W-1:0] cand;
    logic [CNT_W-1:0]                     cand_n;
    logic [CNT_W-1:0]                     emit;
    logic [2:0]                           need;
    logic [23:0]                          acc_sh;
    logic [4:0]                           h;
    logic [4:0]                           res;
    logic [4:0]                           pos;
    logic [6:0]                           thr;
    logic [SAMPLE_W-1:0]                  mask;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;

    always_comb begin
        d    = clamp_depth(r_depth);
        mode = decode_mode(d);
        lim  = ({2'b00, r_row_width} < 17'(MAX_ROW_WIDTH)) ? r_row_width
                                                           : WIDTH_W'(MAX_ROW_WIDTH);
        rem  = (lim > r_pixels) ? (lim - r_pixels) : '0;

        cand        = '0;
        cand_n      = '0;
        need        = 3'd4;
        acc_sh      = '0;
        h           = '0;
        res         = '0;
        pos         = '0;
        thr         = '0;
        mask        = '0;
        n_acc       = r_acc;
        n_bits_held = r_bits_held;
        n_group     = r_group;
        n_fill      = r_fill;
        n_tail      = r_tail;

        unique case (mode)
            MODE_NONE: begin
            end
            MODE_8: begin
                cand[0] = {8'h00, i_byte_value};
                cand_n  = 4'd1;
            end
            MODE_16: begin
                if (r_fill == 3'd0) begin
                    n_group = {24'h0, i_byte_value};
                    n_fill  = 3'd1;
                end else begin
                    cand[0] = {i_byte_value, r_group[7:0]};
                    cand_n  = 4'd1;
                    n_group = '0;
                    n_fill  = '0;
                end
            end
            MODE_10, MODE_12: begin
                need   = (mode == MODE_10) ? 3'd4 : 3'd2;
                n_tail = r_tail || (r_fill == 3'd0 && rem < {12'b0, need});
                if (n_tail) begin
                    // raw tail: every byte is a sample of its own
                    cand[0] = {8'h00, i_byte_value};
                    cand_n  = 4'd1;
                end else if (r_fill < need) begin
                    n_group = r_group | (32'(i_byte_value) << {r_fill[1:0], 3'b000});
                    n_fill  = r_fill + 3'd1;
                    if (i_row_end) begin
                        // unfinished group flushes raw at row end
                        for (int k = 0; k < 4; k++) begin
                            cand[k] = {8'h00, n_group[8*k +: 8]};
                        end
                        cand_n = {1'b0, n_fill};
                    end
                end else begin
                    if (mode == MODE_10) begin
                        cand[0] = {6'b0, i_byte_value[1:0], r_group[7:0]};
                        cand[1] = {6'b0, 2'((i_byte_value & LOW_MASK_1) >> 2), r_group[15:8]};
                        cand[2] = {6'b0, 2'((i_byte_value & LOW_MASK_2) >> 4), r_group[23:16]};
                        cand[3] = {6'b0, 2'((i_byte_value & LOW_MASK_3) >> 6), r_group[31:24]};
                        cand_n  = 4'd4;
                    end else begin
                        cand[0] = {4'b0, r_group[7:0], r_group[15:12]};
                        cand[1] = {4'b0, 4'(r_group[15:8] & NIBBLE_MASK), i_byte_value};
                        cand_n  = 4'd2;
                    end
                    n_group = '0;
                    n_fill  = '0;
                end
            end
            MODE_GEN: begin
                acc_sh = {r_acc[15:0], i_byte_value};
                h      = r_bits_held + 5'd8;
                mask   = 16'((17'd1 << d) - 17'd1);
                res    = h;
                // sample j starts at bit h - (j+1)*d, MSB first
                for (int j = 0; j < MAX_RESULTS; j++) begin
                    thr = 7'(j + 1) * {2'b00, d};
                    if ({2'b00, h} >= thr) begin
                        pos     = 5'({2'b00, h} - thr);
                        cand[j] = 16'(acc_sh >> pos) & mask;
                        cand_n  = CNT_W'(j + 1);
                        res     = pos;
                    end
                end
                n_acc       = acc_sh & ((24'd1 << res) - 24'd1);
                n_bits_held = res;
            end
            default: begin
            end
        endcase

        if (i_row_end) begin
            n_acc       = '0;
            n_bits_held = '0;
            n_group     = '0;
            n_fill      = '0;
            n_tail      = 1'b0;
        end

        emit     = ({11'b0, cand_n} > rem) ? CNT_W'(rem) : cand_n;
        n_pixels = i_row_end ? '0 : (r_pixels + WIDTH_W'(emit));
    end

    assign o_push          = accept && (emit != '0);
    assign o_entry.samples = cand;
    assign o_entry.count   = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= DEPTH_RESET;
            r_row_width <= WIDTH_RESET;
            r_acc       <= '0;
            r_bits_held <= '0;
            r_group     <= '0;
            r_fill      <= '0;
            r_pixels    <= '0;
            r_tail      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_DEPTH: begin
                    r_depth     <= i_cfg_data[DEPTH_W-1:0];
                    r_acc       <= '0;
                    r_bits_held <= '0;
                    r_group     <= '0;
                    r_fill      <= '0;
                    r_tail      <= 1'b0;
                end
                CFG_ROW_WIDTH: begin
                    r_row_width <= i_cfg_data[WIDTH_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            r_acc       <= n_acc;
            r_bits_held <= n_bits_held;
            r_group     <= n_group;
            r_fill      <= n_fill;
            r_pixels    <= n_pixels;
            r_tail      <= n_tail;
        end
    end

    // residue of the bit stream is always shorter than one sample
    a_bits_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_held < 5'd16)
        else $error("bit residue out of range");

    // a group never holds more than four bytes
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 3'd4)
        else $error("group fill out of range");

endmodule

[rtl/core/pru_queue.sv]
// Short entry queue between front and back end.
module pru_queue
    import pru_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_entry    o_head,
    output t_q_status o_status
);

    t_entry             r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // the front end must hold off when the queue is full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into full queue");

endmodule

[rtl/core/pru_back.sv]
// Back end: serializes queued entries into one sample per output transfer.
module pru_back
    import pru_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_entry              i_head,
    input  t_q_status           i_q_status,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SAMPLE_W-1:0] o_sample,
    output logic                o_last
);

    logic                r_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_last;
    logic [IDX_W-1:0]    r_idx;

    logic load;
    logic take;
    logic at_end;

    assign load   = !r_valid || !i_stall;
    assign take   = load && !i_q_status.empty;
    assign at_end = ({1'b0, r_idx} == (i_head.count - 1'b1));
    assign o_pop  = take && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= !i_q_status.empty;
            if (take) begin
                r_idx <= at_end ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_sample <= i_head.samples[r_idx];
            r_last   <= at_end;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;
    assign o_last   = r_last;

    // the read index stays inside the head entry
    a_idx_in_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_status.empty |-> ({1'b0, r_idx} < i_head.count))
        else $error("sample index beyond entry");

endmodule
